// ===== rtl/core/ostt_pkg.sv =====
// shared types and constants for the one-shot timer table
// no dependencies; imported by every module of the block

package ostt_pkg;

  localparam int WORD_W   = 32;
  localparam int SLOT_W   = 4;
  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = 1;
  localparam int Q_CNT_W  = 2;

  typedef enum logic {
    OP_TICK     = 1'b0,
    OP_REGISTER = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_REGISTERED = 2'd0,
    KIND_FULL       = 2'd1,
    KIND_FIRED      = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REG,
    ST_TICK,
    ST_FLUSH
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic [WORD_W-1:0] handler;
    logic [WORD_W-1:0] ctx;
    logic [WORD_W-1:0] delay;
  } cmd_t;

  typedef struct packed {
    kind_e             kind;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] handler;
    logic [WORD_W-1:0] ctx;
    logic              last;
  } result_t;

endpackage

// ===== rtl/core/ostt_front.sv =====
// front end: accepts input transactions, decodes the operation, queues commands
// depends on ostt_pkg

module ostt_front import ostt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic              s_func_i,
  input  logic [WORD_W-1:0] s_handler_i,
  input  logic [WORD_W-1:0] s_ctx_i,
  input  logic [WORD_W-1:0] s_delay_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output cmd_t              cmd_o
);

  cmd_t               q_mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  cmd_t               cmd_in;
  logic               push, pop;

  always_comb begin
    cmd_in.handler = s_handler_i;
    cmd_in.ctx     = s_ctx_i;
    cmd_in.delay   = s_delay_i;
    unique case (s_func_i)
      1'b1:    cmd_in.op = OP_REGISTER;
      default: cmd_in.op = OP_TICK;
    endcase
  end

  assign s_ready_o   = (cnt_q != Q_CNT_W'(Q_DEPTH));
  assign push        = s_valid_i && s_ready_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== rtl/core/ostt_back.sv =====
// back end: slot scan for registration, pipelined slot walk for ticks,
// slot memories, pending fire result and output register; depends on ostt_pkg

module ostt_back import ostt_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cmd_valid_i,
  output logic    cmd_ready_o,
  input  cmd_t    cmd_i,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [SLOT_W+IDX_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

  back_state_e          state_q, state_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic                 s1_vld_q, s1_vld_d;
  logic [IDX_W-1:0]     s1_idx_q, s1_idx_d;
  logic [NUM_SLOTS-1:0] occ_q, occ_d;
  logic                 pend_vld_q, pend_vld_d;
  result_t              pend_q, pend_d;
  logic                 out_vld_q, out_vld_d;
  result_t              out_q, out_d;
  logic [WORD_W-1:0]    req_handler_q, req_ctx_q, req_delay_q;

  logic [WORD_W-1:0]    hdl_mem [NUM_SLOTS];
  logic [WORD_W-1:0]    ctx_mem [NUM_SLOTS];
  logic [WORD_W-1:0]    cnt_mem [NUM_SLOTS];
  logic [WORD_W-1:0]    hdl_rd_q, ctx_rd_q, cnt_rd_q;

  logic                 rd_en, reg_we, cnt_we;
  logic [IDX_W-1:0]     cur_idx, cnt_wa;
  logic [WORD_W-1:0]    cnt_wd;
  logic                 out_free, s1_fire;
  result_t              fire_res;

  assign cur_idx     = idx_q[IDX_W-1:0];
  assign out_free    = !out_vld_q || res_ready_i;
  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;
  assign s1_fire     = s1_vld_q && occ_q[s1_idx_q] && (cnt_rd_q == '0);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    s1_vld_d    = s1_vld_q;
    s1_idx_d    = s1_idx_q;
    occ_d       = occ_q;
    pend_vld_d  = pend_vld_q;
    pend_d      = pend_q;
    out_vld_d   = out_vld_q && !res_ready_i;
    out_d       = out_q;
    cmd_ready_o = 1'b0;
    rd_en       = 1'b0;
    reg_we      = 1'b0;
    cnt_we      = 1'b0;
    cnt_wa      = cur_idx;
    cnt_wd      = req_delay_q;

    fire_res.kind    = KIND_FIRED;
    fire_res.slot    = to_slot(s1_idx_q);
    fire_res.handler = hdl_rd_q;
    fire_res.ctx     = ctx_rd_q;
    fire_res.last    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          idx_d    = '0;
          s1_vld_d = 1'b0;
          state_d  = (cmd_i.op == OP_REGISTER) ? ST_REG : ST_TICK;
        end
      end
      ST_REG: begin
        if (!occ_q[cur_idx]) begin
          if (out_free) begin
            reg_we          = 1'b1;
            cnt_we          = 1'b1;
            occ_d[cur_idx]  = (req_handler_q != '0);
            out_vld_d       = 1'b1;
            out_d.kind      = KIND_REGISTERED;
            out_d.slot      = to_slot(cur_idx);
            out_d.handler   = '0;
            out_d.ctx       = '0;
            out_d.last      = 1'b1;
            state_d         = ST_IDLE;
          end
        end else if (idx_q == CNT_W'(NUM_SLOTS - 1)) begin
          if (out_free) begin
            out_vld_d     = 1'b1;
            out_d.kind    = KIND_FULL;
            out_d.slot    = '0;
            out_d.handler = '0;
            out_d.ctx     = '0;
            out_d.last    = 1'b1;
            state_d       = ST_IDLE;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_TICK: begin
        if (!s1_vld_q && idx_q == CNT_W'(NUM_SLOTS)) begin
          state_d = ST_FLUSH;
        end else if (!(s1_fire && pend_vld_q && !out_free)) begin
          rd_en    = (idx_q != CNT_W'(NUM_SLOTS));
          s1_vld_d = rd_en;
          s1_idx_d = cur_idx;
          if (rd_en) begin
            idx_d = idx_q + 1'b1;
          end
          if (s1_vld_q && occ_q[s1_idx_q]) begin
            if (s1_fire) begin
              occ_d[s1_idx_q] = 1'b0;
              if (pend_vld_q) begin
                out_vld_d = 1'b1;
                out_d     = pend_q;
              end
              pend_vld_d = 1'b1;
              pend_d     = fire_res;
            end else begin
              cnt_we = 1'b1;
              cnt_wa = s1_idx_q;
              cnt_wd = cnt_rd_q - 1'b1;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_vld_d  = 1'b1;
          out_d      = pend_q;
          out_d.last = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      s1_vld_q   <= 1'b0;
      occ_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      s1_vld_q   <= s1_vld_d;
      occ_q      <= occ_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= s1_idx_d;
    pend_q   <= pend_d;
    out_q    <= out_d;
    if (cmd_valid_i && cmd_ready_o) begin
      req_handler_q <= cmd_i.handler;
      req_ctx_q     <= cmd_i.ctx;
      req_delay_q   <= cmd_i.delay;
    end
  end

  // slot memories, registered read
  always_ff @(posedge clk_i) begin
    if (reg_we) begin
      hdl_mem[cur_idx] <= req_handler_q;
      ctx_mem[cur_idx] <= req_ctx_q;
    end
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (rd_en) begin
      hdl_rd_q <= hdl_mem[cur_idx];
      ctx_rd_q <= ctx_mem[cur_idx];
      cnt_rd_q <= cnt_mem[cur_idx];
    end
  end

endmodule

// ===== rtl/core/one_shot_timer_table.sv =====
// top level of the one-shot timer table: stream ports, front queue and back engine
// depends on ostt_pkg, ostt_front and ostt_back
//
// channel   direction  handshake                  payload
// s_axis    in         s_axis_tvalid/tready       tuser func; tdata handler, context, delay
// m_axis    out        m_axis_tvalid/tready       tuser kind; tdata slot, handler, context; tlast
//
// a register transaction scans slots one per cycle from slot 0 until it finds a free one or all are taken
// a tick walks every slot through the slot memory read port, one slot per cycle
// while no fired result is held back by a stalled output
// the two-entry input queue accepts until full while the engine works or the output stalls
// reset marks every slot free at once; no clearing pass

module one_shot_timer_table import ostt_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // handler, context_req, delay
  input  logic        s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // slot, fired_handler, fired_context, zero pad
  output logic [1:0]  m_axis_tuser,  // kind
  output logic        m_axis_tlast
);

  logic    cmd_valid, cmd_ready;
  cmd_t    cmd;
  result_t res;

  ostt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_func_i    (s_axis_tuser),
    .s_handler_i (s_axis_tdata[31:0]),
    .s_ctx_i     (s_axis_tdata[63:32]),
    .s_delay_i   (s_axis_tdata[95:64]),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  ostt_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {4'b0000, res.ctx, res.handler, res.slot};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule
